### rtl/core/fcct_pkg.sv
package fcct_pkg;

	// field widths
	localparam int ELAPSED_W = 10;
	localparam int CNT_W     = 8;
	localparam int ACC_W     = 32;
	localparam int FLAGS_W   = 4;
	localparam int TIMERS    = 4;
	localparam int TIMER_W   = 2;
	localparam int MODE_W    = 4;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 8;

	// stream packing, padded to whole bytes
	localparam int S_DATA_W = 16;
	localparam int M_DATA_W = 16;

	// default prescaler periods in cpu cycles
	localparam int DEF_RATE_DIV1   = 8;
	localparam int DEF_RATE_DIV4   = 32;
	localparam int DEF_RATE_DIV16  = 128;
	localparam int DEF_RATE_DIV256 = 2048;

	// register indexes of the configuration channel
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_RUN_ENABLE  = 3'd0,
		CFG_MODE_LOW    = 3'd1,
		CFG_MODE_HIGH   = 3'd2,
		CFG_THRESHOLD_0 = 3'd3,
		CFG_THRESHOLD_1 = 3'd4,
		CFG_THRESHOLD_2 = 3'd5,
		CFG_THRESHOLD_3 = 3'd6
	} cfg_idx_t;

	// sequencer states, one-hot
	typedef enum logic [7:0] {
		ST_IDLE  = 8'b00000001,
		ST_LOAD  = 8'b00000010,
		ST_MUL   = 8'b00000100,
		ST_QUOT  = 8'b00001000,
		ST_REM   = 8'b00010000,
		ST_FIX   = 8'b00100000,
		ST_CHECK = 8'b01000000,
		ST_DONE  = 8'b10000000
	} state_t;

	// what drives a timer's count
	typedef enum logic [1:0] {
		SRC_IDLE  = 2'd0,
		SRC_EVENT = 2'd1,
		SRC_RATE  = 2'd2
	} src_kind_t;

	localparam logic [1:0] MODE_EVENT = 2'd0;
	localparam logic [1:0] MODE_RATE_A = 2'd1;
	localparam logic [1:0] MODE_RATE_B = 2'd2;
	localparam logic [1:0] MODE_RATE_C = 2'd3;
	localparam logic [TIMER_W-1:0] TIMER_IDLE_CAPABLE = 2'd2;

	// mode 0 is an event source except on timer 2, where it stops counting
	function automatic src_kind_t src_kind(input logic [TIMER_W-1:0] t, input logic [1:0] mode);
		src_kind_t k;
		if (mode != MODE_EVENT) begin
			k = SRC_RATE;
		end else if (t == TIMER_IDLE_CAPABLE) begin
			k = SRC_IDLE;
		end else begin
			k = SRC_EVENT;
		end
		return k;
	endfunction

endpackage

### rtl/core/four_channel_chained_timers.sv
// Four 8-bit up-counters, each fed by a 32-bit cycle accumulator that gains
// elapsed_cycles on every transfer but is cleared when its timer counts an
// event. A running counter in a prescaled mode takes every whole period held
// in its accumulator, keeps the remainder, wraps at 8 bits and clears on
// reaching a nonzero threshold, which sets its match flag. Timer 0 can count
// latched hblank events, timers 1 and 3 can count matches of the timer below.
// The timers are worked one after the other by one adder and one shared 32 by
// 32 multiplier: a prescaled timer estimates its period count from a scaled
// reciprocal of the period, multiplies back for the remainder and corrects by
// at most one period. A result reaches the output register as the sequencer
// leaves its last state, and the input is ready again in that same cycle. The
// result sits in an output register, so the next item can start while it
// waits; a next result that finds it still full holds the sequencer in its
// last state. The configuration channel is always ready and is meant to be
// written while idle.
module four_channel_chained_timers
	import fcct_pkg::*;
#(
	parameter int RATE_DIV1   = DEF_RATE_DIV1,
	parameter int RATE_DIV4   = DEF_RATE_DIV4,
	parameter int RATE_DIV16  = DEF_RATE_DIV16,
	parameter int RATE_DIV256 = DEF_RATE_DIV256
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [S_DATA_W-1:0]   s_tdata,   // elapsed_cycles[9:0], line_end[10], hblank_level[11]
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [M_DATA_W-1:0]   m_tdata,   // match_flags[3:0], count_low_timer[11:4]
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int DBL_W     = 2 * ACC_W;
	localparam int HALF_DIV1 = (RATE_DIV1 / 2 == 0) ? 1 : RATE_DIV1 / 2;

	localparam logic [ACC_W-1:0] R_DIV1   = ACC_W'(RATE_DIV1);
	localparam logic [ACC_W-1:0] R_HALF1  = ACC_W'(HALF_DIV1);
	localparam logic [ACC_W-1:0] R_DIV4   = ACC_W'(RATE_DIV4);
	localparam logic [ACC_W-1:0] R_DIV16  = ACC_W'(RATE_DIV16);
	localparam logic [ACC_W-1:0] R_DIV256 = ACC_W'(RATE_DIV256);
	localparam logic [TIMER_W-1:0] LAST_TIMER = TIMER_W'(TIMERS - 1);

	// 2^32 over each period; the halved period's reciprocal is held just below 2^32 if it overflows
	localparam logic [DBL_W-1:0] SPAN     = {{(ACC_W - 1){1'b0}}, 1'b1, {ACC_W{1'b0}}};
	localparam logic [DBL_W-1:0] Q_DIV1   = SPAN / DBL_W'(RATE_DIV1);
	localparam logic [DBL_W-1:0] Q_HALF1  = SPAN / DBL_W'(HALF_DIV1);
	localparam logic [DBL_W-1:0] Q_DIV4   = SPAN / DBL_W'(RATE_DIV4);
	localparam logic [DBL_W-1:0] Q_DIV16  = SPAN / DBL_W'(RATE_DIV16);
	localparam logic [DBL_W-1:0] Q_DIV256 = SPAN / DBL_W'(RATE_DIV256);
	localparam logic [ACC_W-1:0] K_DIV1   = Q_DIV1[ACC_W-1:0];
	localparam logic [ACC_W-1:0] K_HALF1  =
		Q_HALF1[ACC_W] ? {ACC_W{1'b1}} : Q_HALF1[ACC_W-1:0];
	localparam logic [ACC_W-1:0] K_DIV4   = Q_DIV4[ACC_W-1:0];
	localparam logic [ACC_W-1:0] K_DIV16  = Q_DIV16[ACC_W-1:0];
	localparam logic [ACC_W-1:0] K_DIV256 = Q_DIV256[ACC_W-1:0];

	state_t state_q;

	// configuration registers
	logic [FLAGS_W-1:0]  run_q;
	logic [MODE_W-1:0]   mode_lo_q;
	logic [MODE_W-1:0]   mode_hi_q;
	logic [CNT_W-1:0]    thr_q [TIMERS];

	// timer state
	logic [CNT_W-1:0]    cnt_q [TIMERS];
	logic [ACC_W-1:0]    acc_q [TIMERS];
	logic                latch_q;

	// per-item working registers
	logic [ELAPSED_W-1:0] cycles_q;
	logic [TIMER_W-1:0]   t_q;
	logic [FLAGS_W-1:0]   flags_q;
	logic [ACC_W-1:0]     dvd_q;
	logic [ACC_W-1:0]     divisor_q;
	logic [ACC_W-1:0]     mul_a_q;   // quotient estimate once the first product is taken
	logic [ACC_W-1:0]     mul_b_q;
	logic [DBL_W-1:0]     prod_q;
	logic [ACC_W-1:0]     rem_q;
	logic                 back_q;

	// output register
	logic                 m_valid_q;
	logic [M_DATA_W-1:0]  m_data_q;

	logic [MODE_W-1:0]    mode_pair;
	logic [1:0]           mode;
	src_kind_t            kind;
	logic                 running;
	logic                 event_hit;
	logic [ACC_W-1:0]     rate;
	logic [ACC_W-1:0]     recip;
	logic [ACC_W-1:0]     acc_sum;
	logic [DBL_W-1:0]     mul;
	logic                 s_xfer;
	logic                 out_free;

	assign s_tready  = (state_q == ST_IDLE);
	assign s_xfer    = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;
	assign m_tvalid  = m_valid_q;
	assign m_tdata   = m_data_q;
	assign out_free  = !m_valid_q || m_tready;

	// source decode of the timer being worked
	always_comb begin
		mode_pair = t_q[1] ? mode_hi_q : mode_lo_q;
		mode      = t_q[0] ? mode_pair[3:2] : mode_pair[1:0];
		kind      = src_kind(t_q, mode);
		running   = run_q[t_q];
	end

	// event of the chained or hblank source
	always_comb begin
		unique case (t_q)
			2'd0:    event_hit = latch_q;
			2'd1:    event_hit = flags_q[0];
			2'd3:    event_hit = flags_q[2];
			default: event_hit = 1'b0;
		endcase
	end

	// prescaler period and its reciprocal for the timer being worked
	always_comb begin
		rate  = R_DIV1;
		recip = K_DIV1;
		unique case (t_q)
			2'd0: begin
				unique case (mode)
					MODE_RATE_B: begin
						rate  = R_DIV4;
						recip = K_DIV4;
					end
					MODE_RATE_C: begin
						rate  = R_DIV16;
						recip = K_DIV16;
					end
					default: begin
						rate  = R_DIV1;
						recip = K_DIV1;
					end
				endcase
			end
			2'd2: begin
				unique case (mode)
					MODE_RATE_B: begin
						rate  = R_DIV4;
						recip = K_DIV4;
					end
					MODE_RATE_C: begin
						rate  = R_DIV16;
						recip = K_DIV16;
					end
					default: begin
						rate  = R_HALF1;
						recip = K_HALF1;
					end
				endcase
			end
			default: begin
				unique case (mode)
					MODE_RATE_B: begin
						rate  = R_DIV16;
						recip = K_DIV16;
					end
					MODE_RATE_C: begin
						rate  = R_DIV256;
						recip = K_DIV256;
					end
					default: begin
						rate  = R_DIV1;
						recip = K_DIV1;
					end
				endcase
			end
		endcase
	end

	// shared adder and 32 by 32 multiplier
	assign acc_sum = acc_q[t_q] + {{(ACC_W - ELAPSED_W){1'b0}}, cycles_q};
	assign mul     = {{ACC_W{1'b0}}, mul_a_q} * {{ACC_W{1'b0}}, mul_b_q};

	// sequencer and datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			run_q     <= '0;
			mode_lo_q <= '0;
			mode_hi_q <= '0;
			latch_q   <= 1'b0;
			cycles_q  <= '0;
			t_q       <= '0;
			flags_q   <= '0;
			dvd_q     <= '0;
			divisor_q <= '0;
			mul_a_q   <= '0;
			mul_b_q   <= '0;
			prod_q    <= '0;
			rem_q     <= '0;
			back_q    <= 1'b0;
			for (int i = 0; i < TIMERS; i++) begin
				thr_q[i] <= '0;
				cnt_q[i] <= '0;
				acc_q[i] <= '0;
			end
		end else begin
			// register writes
			if (cfg_valid) begin
				unique case (cfg_index)
					CFG_RUN_ENABLE: begin
						run_q <= cfg_data[FLAGS_W-1:0];
						for (int i = 0; i < TIMERS; i++) begin
							if (!cfg_data[i]) cnt_q[i] <= '0;
						end
					end
					CFG_MODE_LOW:    mode_lo_q <= cfg_data[MODE_W-1:0];
					CFG_MODE_HIGH:   mode_hi_q <= cfg_data[MODE_W-1:0];
					CFG_THRESHOLD_0: thr_q[0] <= cfg_data;
					CFG_THRESHOLD_1: thr_q[1] <= cfg_data;
					CFG_THRESHOLD_2: thr_q[2] <= cfg_data;
					CFG_THRESHOLD_3: thr_q[3] <= cfg_data;
					default: ;
				endcase
			end

			unique case (state_q)
				ST_IDLE: begin
					if (s_xfer) begin
						cycles_q <= s_tdata[ELAPSED_W-1:0];
						if (s_tdata[ELAPSED_W]) latch_q <= s_tdata[ELAPSED_W+1];
						t_q      <= '0;
						flags_q  <= '0;
						state_q  <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					if (running && kind == SRC_RATE) begin
						dvd_q     <= acc_sum;
						mul_a_q   <= acc_sum;
						mul_b_q   <= recip;
						divisor_q <= rate;
						back_q    <= 1'b0;
						state_q   <= ST_MUL;
					end else begin
						if (running && kind == SRC_EVENT && event_hit) begin
							cnt_q[t_q] <= cnt_q[t_q] + 1'b1;
							acc_q[t_q] <= '0;
							if (t_q == '0) latch_q <= 1'b0;
						end else begin
							acc_q[t_q] <= acc_sum;
						end
						state_q <= ST_CHECK;
					end
				end
				ST_MUL: begin
					prod_q <= mul;
					if (back_q) begin
						state_q <= ST_REM;
					end else begin
						state_q <= ST_QUOT;
					end
				end
				ST_QUOT: begin
					// estimate is the true count or one below it
					mul_a_q <= prod_q[DBL_W-1:ACC_W];
					mul_b_q <= divisor_q;
					back_q  <= 1'b1;
					state_q <= ST_MUL;
				end
				ST_REM: begin
					rem_q   <= dvd_q - prod_q[ACC_W-1:0];
					state_q <= ST_FIX;
				end
				ST_FIX: begin
					// one period left over means the estimate was one short
					if (rem_q >= divisor_q) begin
						acc_q[t_q] <= rem_q - divisor_q;
						cnt_q[t_q] <= cnt_q[t_q] + mul_a_q[CNT_W-1:0] + 1'b1;
					end else begin
						acc_q[t_q] <= rem_q;
						cnt_q[t_q] <= cnt_q[t_q] + mul_a_q[CNT_W-1:0];
					end
					state_q <= ST_CHECK;
				end
				ST_CHECK: begin
					if (running && thr_q[t_q] != '0 && cnt_q[t_q] >= thr_q[t_q]) begin
						cnt_q[t_q]   <= '0;
						flags_q[t_q] <= 1'b1;
					end
					if (t_q == LAST_TIMER) begin
						state_q <= ST_DONE;
					end else begin
						t_q     <= t_q + 1'b1;
						state_q <= ST_LOAD;
					end
				end
				ST_DONE: begin
					if (out_free) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// output register, loaded when the sequencer finishes an item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
			m_data_q  <= '0;
		end else if (state_q == ST_DONE && out_free) begin
			m_valid_q <= 1'b1;
			m_data_q  <= {{(M_DATA_W - FLAGS_W - CNT_W){1'b0}}, cnt_q[0], flags_q};
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

endmodule

### rtl/core/fcct_checker.sv
module fcct_checker
	import fcct_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 s_tvalid,
	input logic                 s_tready,
	input logic                 m_tvalid,
	input logic                 m_tready,
	input logic [M_DATA_W-1:0]  m_tdata,
	input logic                 cfg_ready
);

	// an accepted item keeps the input busy on the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input ready right after a transfer");

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// a timer 0 match always leaves timer 0 at zero
	a_match_clears: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[0] |-> m_tdata[FLAGS_W+CNT_W-1:FLAGS_W] == '0)
		else $error("timer 0 matched but count not cleared");

	// padding bits of the result stay zero
	a_out_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[M_DATA_W-1:FLAGS_W+CNT_W] == '0)
		else $error("nonzero padding in result");

	// configuration writes never stall
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready)
		else $error("configuration channel stalled");

endmodule

bind four_channel_chained_timers fcct_checker u_fcct_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.s_tvalid  (s_tvalid),
	.s_tready  (s_tready),
	.m_tvalid  (m_tvalid),
	.m_tready  (m_tready),
	.m_tdata   (m_tdata),
	.cfg_ready (cfg_ready)
);
